[hw/rtl/lcdn_pkg.sv]
// Shared types, codes and constants for the character LCD nibble controller.
package lcdn_pkg;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_PUT   = 2'd1,
    OP_GOTO  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Register indexes on the configuration port (paddr[2])
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Command queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Display command bytes
  localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;

  // Waits in microseconds
  localparam logic [10:0] WAIT_CLEAR_US = 11'd2000;
  localparam logic [10:0] WAIT_CMD_US   = 11'd50;
  localparam logic [15:0] WAKE0_US      = 16'd40000;
  localparam logic [15:0] WAKE1_US      = 16'd5000;
  localparam logic [15:0] WAKE2_US      = 16'd100;

  // Register values as the hardware sees them
  typedef struct packed {
    logic [5:0] columns;
    logic [2:0] rows;
  } cfg_t;

  // One queued command for the back end
  typedef struct packed {
    op_t        kind;
    logic [7:0] byte_a;    // data byte of a put
    logic       has_addr;  // put wrapped: set-address follows
    logic [7:0] byte_b;    // set-address byte
  } cmd_t;

  // Row start addresses in display RAM
  function automatic logic [6:0] line_base(input logic [1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h20;
      default: base = 7'h60;
    endcase
    return base;
  endfunction

  // Columns in use, limited to 1..32
  function automatic logic [5:0] eff_cols(input logic [5:0] c);
    logic [5:0] r;
    if (c == 6'd0) r = 6'd1;
    else if (c > 6'd32) r = 6'd32;
    else r = c;
    return r;
  endfunction

  // Rows in use, limited to 1..4
  function automatic logic [2:0] eff_rows(input logic [2:0] c);
    logic [2:0] r;
    if (c == 3'd0) r = 3'd1;
    else if (c > 3'd4) r = 3'd4;
    else r = c;
    return r;
  endfunction

  // Command bytes sent after the wake-up nibbles
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_FUNC_SET;
      2'd1:    b = CMD_DISP_OFF;
      2'd2:    b = CMD_CLEAR;
      default: b = CMD_DISP_ON;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/lcdn_regs.sv]
// Configuration registers behind the APB-style port.
module lcdn_regs import lcdn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [5:0] columns_r;
  logic [2:0] rows_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 6'd16;
      rows_r    <= 3'd2;
    end else if (wr_en) begin
      if (paddr[2] == REG_COLUMNS) columns_r <= pwdata[5:0];
      else                         rows_r    <= pwdata[2:0];
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == REG_COLUMNS) prdata = {26'd0, columns_r};
    else                         prdata = {29'd0, rows_r};
  end

  assign cfg.columns = columns_r;
  assign cfg.rows    = rows_r;

endmodule

[hw/rtl/lcdn_front.sv]
// Front end: accepts operations, tracks the cursor, builds queued commands.
module lcdn_front import lcdn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_code,
  input  logic [5:0] in_target_col,
  input  logic [2:0] in_target_row,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [4:0] cursor_col_r, cursor_col_nxt;
  logic [1:0] cursor_row_r, cursor_row_nxt;
  logic [5:0] cols_e;
  logic [2:0] rows_e;
  op_t        op;

  // put character: next column and wrap target
  logic [5:0] col_inc;
  logic       put_wrap;
  logic [2:0] row_inc;
  logic [1:0] put_row;

  // goto: wrapped position and address
  logic       g_wrap;
  logic [5:0] g_col;
  logic [3:0] g_row_a;
  logic [1:0] g_row;
  logic [6:0] g_addr;

  assign op       = op_t'(in_operation);
  assign cols_e   = eff_cols(cfg.columns);
  assign rows_e   = eff_rows(cfg.rows);
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign col_inc  = {1'b0, cursor_col_r} + 6'd1;
  assign put_wrap = col_inc >= cols_e;
  assign row_inc  = {1'b0, cursor_row_r} + 3'd1;
  assign put_row  = (row_inc >= rows_e) ? 2'd0 : row_inc[1:0];

  assign g_wrap  = in_target_col >= cols_e;
  assign g_col   = g_wrap ? 6'd0 : in_target_col;
  assign g_row_a = g_wrap ? ({1'b0, in_target_row} + 4'd1) : {1'b0, in_target_row};
  assign g_row   = (g_row_a >= {1'b0, rows_e}) ? 2'd0 : g_row_a[1:0];
  assign g_addr  = line_base(g_row) + g_col[6 - 1:0];

  // command build and cursor update
  always_comb begin
    cmd.kind       = op;
    cmd.byte_a     = in_char_code;
    cmd.has_addr   = 1'b0;
    cmd.byte_b     = CMD_SET_ADDR;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    case (op)
      OP_INIT: begin
        cursor_col_nxt = 5'd0;
        cursor_row_nxt = 2'd0;
      end
      OP_PUT: begin
        if (put_wrap) begin
          cmd.has_addr   = 1'b1;
          cmd.byte_b     = CMD_SET_ADDR | {1'b0, line_base(put_row)};
          cursor_col_nxt = 5'd0;
          cursor_row_nxt = put_row;
        end else begin
          cursor_col_nxt = col_inc[4:0];
        end
      end
      OP_GOTO: begin
        cmd.byte_b     = CMD_SET_ADDR | {1'b0, g_addr};
        cursor_col_nxt = g_col[4:0];
        cursor_row_nxt = g_row;
      end
      default: begin
      end
    endcase
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= 5'd0;
      cursor_row_r <= 2'd0;
    end else if (push) begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

endmodule

[hw/rtl/lcdn_queue.sv]
// Short command queue between front and back ends.
module lcdn_queue import lcdn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = count_r == QCNT_W'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head       = ent_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

[hw/rtl/lcdn_back.sv]
// Back end: steps through queued commands, one nibble beat per cycle while out_ready holds.
module lcdn_back import lcdn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_register_select,
  output logic [3:0]  out_nibble,
  output logic [15:0] out_wait_before_us,
  output logic [10:0] out_wait_after_us,
  output logic        out_last
);

  logic [3:0]  step_r;
  logic        out_valid_r;
  logic        rs_r;
  logic [3:0]  nib_r;
  logic [15:0] before_r;
  logic [10:0] after_r;
  logic        last_r;

  logic        load;
  logic [3:0]  n_steps;
  logic        is_last;
  logic [7:0]  cur_byte;
  logic        rs_c;
  logic [3:0]  nib_c;
  logic [15:0] before_c;
  logic [10:0] after_c;

  // nibble for the current step of the head command
  always_comb begin
    n_steps  = 4'd2;
    cur_byte = CMD_CLEAR;
    rs_c     = 1'b0;
    nib_c    = 4'd0;
    before_c = 16'd0;
    after_c  = 11'd0;
    case (head.kind)
      OP_INIT: begin
        n_steps  = 4'd12;
        cur_byte = init_byte(step_r[2:1] + 2'd2);
      end
      OP_PUT: begin
        n_steps  = head.has_addr ? 4'd4 : 4'd2;
        cur_byte = step_r[1] ? head.byte_b : head.byte_a;
        rs_c     = !step_r[1];
      end
      OP_GOTO: begin
        cur_byte = head.byte_b;
      end
      default: begin
        cur_byte = CMD_CLEAR;
      end
    endcase
    nib_c = step_r[0] ? cur_byte[3:0] : cur_byte[7:4];
    // only the clear command gets the long wait; a data byte never does
    if (step_r[0]) after_c = (!rs_c && cur_byte == CMD_CLEAR) ? WAIT_CLEAR_US : WAIT_CMD_US;
    // wake-up nibbles at the start of init
    if (head.kind == OP_INIT && step_r < 4'd4) begin
      after_c = 11'd0;
      case (step_r[1:0])
        2'd0: begin
          nib_c    = 4'h3;
          before_c = WAKE0_US;
        end
        2'd1: begin
          nib_c    = 4'h3;
          before_c = WAKE1_US;
        end
        2'd2: begin
          nib_c    = 4'h3;
          before_c = WAKE2_US;
        end
        default: begin
          nib_c    = 4'h2;
          before_c = 16'd0;
        end
      endcase
    end
  end

  assign is_last = step_r == (n_steps - 4'd1);
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign pop     = load && is_last;

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) step_r <= is_last ? 4'd0 : step_r + 4'd1;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      rs_r     <= rs_c;
      nib_r    <= nib_c;
      before_r <= before_c;
      after_r  <= after_c;
      last_r   <= is_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = rs_r;
  assign out_nibble          = nib_r;
  assign out_wait_before_us  = before_r;
  assign out_wait_after_us   = after_r;
  assign out_last            = last_r;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> step_r < n_steps)
    else $error("step past end of command");
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> step_r == 4'd0)
    else $error("step not rewound after last beat");
`endif

endmodule

[hw/rtl/char_lcd_nibble_controller.sv]
// Top level of the character LCD nibble controller.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one operation per beat: init,
//   put character, goto or clear. Output channel (out_valid/out_ready)
//   gives one nibble transfer per beat with register select, the nibble,
//   the waits before and after the enable pulse, and out_last on the final
//   transfer of an operation. columns and rows sit on the APB-style port
//   at byte addresses 0 and 4; write them only while the block is idle.
//   The first nibble of an accepted operation is registered first in the
//   queue, then in the back-end output register.
//   Throughput: one nibble per cycle while out_ready holds, set by the
//   step counter: put is 2 nibbles (4 on wrap), goto and clear 2, init 12.
//   A 4-entry command queue lets the front accept while the back works.
//   Reset sets columns 16, rows 2, cursor to zero and empties the queue.
//   When out_ready is low the held nibble stays put, the back end stalls,
//   and the front keeps accepting until the queue fills.
module char_lcd_nibble_controller import lcdn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [5:0]  in_target_col,
  input  logic [2:0]  in_target_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_register_select,
  output logic [3:0]  out_nibble,
  output logic [15:0] out_wait_before_us,
  output logic [10:0] out_wait_after_us,
  output logic        out_last
);

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic head_valid;

  // configuration registers
  lcdn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept and classify
  lcdn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_target_col (in_target_col),
    .in_target_row (in_target_row),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  // command queue
  lcdn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // nibble sequencer
  lcdn_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_before_us  (out_wait_before_us),
    .out_wait_after_us   (out_wait_after_us),
    .out_last            (out_last)
  );

endmodule
